FILE: rtl/lbm_pkg.sv
`default_nettype none

package lbm_pkg;

  localparam int unsigned NODES   = 256;
  localparam int unsigned IDX_W   = $clog2(NODES);
  localparam int unsigned LINK_W  = IDX_W + 1;
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned DATA_W  = 48;
  localparam int unsigned TOTAL_W = 24;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // A link carries its node index below a top bit that flags "no node".
  typedef logic [LINK_W-1:0] link_t;
  localparam link_t LINK_NONE = '1;

  typedef enum logic [3:0] {
    K_ALLOC        = 4'd0,
    K_ALLOC_ATTACH = 4'd1,
    K_ATTACH       = 4'd2,
    K_FREE         = 4'd3,
    K_FREE_HEAD    = 4'd4,
    K_PUT_HEAD     = 4'd5,
    K_PUT_TAIL     = 4'd6,
    K_NEXT         = 4'd7,
    K_LENGTH       = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_NONE    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_ALLOC_RD,
    S_FREE_RD,
    S_TAIL_WALK,
    S_TAIL_END,
    S_NEXT_RD,
    S_LEN_WALK
  } state_e;

  function automatic logic is_node(logic [8:0] raw);
    return !raw[8] && (32'(raw[7:0]) < NODES);
  endfunction

  function automatic logic [IDX_W-1:0] to_idx(logic [8:0] raw);
    return IDX_W'(raw[7:0]);
  endfunction

  function automatic logic [8:0] to_field(link_t l);
    return l[LINK_W-1] ? 9'h1FF : 9'(l[IDX_W-1:0]);
  endfunction

  // Link the clearing pass after reset writes into each entry.
  function automatic link_t reset_link(logic [IDX_W-1:0] idx);
    return (32'(idx) == NODES - 1) ? LINK_NONE : {1'b0, idx + IDX_W'(1)};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lbm_ram.sv
`default_nettype none

module lbm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/linked_buffer_list_manager.sv
`default_nettype none

// Buffer-descriptor manager: one next-link memory holds the free list and all
// caller chains, a second memory holds each node's data handle and size. One
// transaction in gives exactly one transaction out. After reset the block
// writes the initial free chain into all NODES (256) entries of the link
// memory and clears the data memory, with in_ready_o low; the first
// transaction is accepted after that pass. Attach, free, put_head, unused
// kinds, every operation on a missing node, an alloc that finds the free list
// empty, a put_tail on an empty chain and a length of an empty chain finish
// without a memory read; alloc, free_head and next wait for one read of the
// link memory. A length walk and a tail append visit the chain node by node;
// a chain with no end within NODES nodes ends either walk after NODES nodes,
// since the single read port of the memories visits one node per cycle.
// A finished result waits in the output register while the next transaction
// runs; a result still waiting there when the next one is ready holds that
// one until out_ready_i takes it.
module linked_buffer_list_manager (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic        [3:0]  kind_i,
  input  wire logic signed [8:0]  node_index_i,
  input  wire logic signed [8:0]  list_head_i,
  input  wire logic        [31:0] data_handle_i,
  input  wire logic        [15:0] data_size_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed      [8:0]  node_result_o,
  output logic signed      [8:0]  link_result_o,
  output logic             [31:0] handle_result_o,
  output logic             [15:0] size_result_o,
  output logic             [23:0] total_length_o,
  output logic             [1:0]  status_o
);

  import lbm_pkg::*;

  state_e state_q, state_d;

  logic [3:0]       kind_q;
  logic [IDX_W-1:0] node_q;
  logic             node_ok_q;
  link_t            head_q;
  logic [31:0]      handle_q;
  logic [15:0]      size_q;

  link_t            fh_q, fh_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0] steps_q, steps_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             link_we, data_we;
  logic [IDX_W-1:0] link_waddr, data_waddr;
  link_t            link_wdata;
  logic [DATA_W-1:0] data_wdata;
  link_t            link_rdata;
  logic [DATA_W-1:0] data_rdata;
  logic [TOTAL_W:0] sum_w;
  logic [TOTAL_W-1:0] sum_sat;

  logic             out_valid_q, out_free, load_out, in_fire;
  logic [8:0]       node_res_q, link_res_q;
  logic [31:0]      handle_res_q;
  logic [15:0]      size_res_q;
  logic [23:0]      total_res_q;
  logic [1:0]       status_res_q;

  logic [8:0]       res_node, res_link;
  logic [31:0]      res_handle;
  logic [15:0]      res_size;
  logic [23:0]      res_total;
  status_e          res_status;

  lbm_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NODES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (link_rdata)
  );

  lbm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NODES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (data_waddr),
    .wdata_i (data_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (data_rdata)
  );

  assign sum_w   = {1'b0, total_q} + (TOTAL_W + 1)'(data_rdata[15:0]);
  assign sum_sat = (sum_w > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_w[TOTAL_W-1:0];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    fh_d       = fh_q;
    cur_d      = cur_q;
    steps_d    = steps_q;
    total_d    = total_q;
    rd_en      = 1'b0;
    rd_addr    = cur_q;
    link_we    = 1'b0;
    link_waddr = node_q;
    link_wdata = LINK_NONE;
    data_we    = 1'b0;
    data_waddr = node_q;
    data_wdata = '0;
    load_out   = 1'b0;
    res_node   = 9'h1FF;
    res_link   = 9'h1FF;
    res_handle = '0;
    res_size   = '0;
    res_total  = '0;
    res_status = ST_OK;

    unique case (state_q)
      S_CLEAR: begin
        // Write the initial free chain and zero data, one entry per cycle.
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = reset_link(cur_q);
        data_we    = 1'b1;
        data_waddr = cur_q;
        cur_d      = cur_q + IDX_W'(1);
        if (cur_q == IDX_W'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (kind_e'(kind_q))
          K_ALLOC, K_ALLOC_ATTACH: begin
            if (fh_q[LINK_W-1]) begin
              res_status = ST_NO_FREE;
              if (out_free) begin
                load_out = 1'b1;
                state_d  = S_IDLE;
              end
            end else begin
              rd_en   = 1'b1;
              rd_addr = fh_q[IDX_W-1:0];
              state_d = S_ALLOC_RD;
            end
          end
          K_ATTACH: begin
            if (!node_ok_q) begin
              res_status = ST_NONE;
            end
            if (out_free) begin
              data_we    = node_ok_q;
              data_wdata = {handle_q, size_q};
              load_out   = 1'b1;
              state_d    = S_IDLE;
            end
          end
          K_FREE: begin
            if (!node_ok_q) begin
              res_status = ST_NONE;
            end
            if (out_free) begin
              data_we    = node_ok_q;
              link_we    = node_ok_q;
              link_wdata = fh_q;
              if (node_ok_q) begin
                fh_d = {1'b0, node_q};
              end
              load_out = 1'b1;
              state_d  = S_IDLE;
            end
          end
          K_FREE_HEAD: begin
            if (node_ok_q) begin
              rd_en   = 1'b1;
              rd_addr = node_q;
              state_d = S_FREE_RD;
            end else begin
              res_status = ST_NONE;
              res_node   = to_field(head_q);
              if (out_free) begin
                load_out = 1'b1;
                state_d  = S_IDLE;
              end
            end
          end
          K_PUT_HEAD: begin
            if (node_ok_q) begin
              res_node = to_field({1'b0, node_q});
            end else begin
              res_status = ST_NONE;
              res_node   = to_field(head_q);
            end
            if (out_free) begin
              link_we    = node_ok_q;
              link_wdata = head_q;
              load_out   = 1'b1;
              state_d    = S_IDLE;
            end
          end
          K_PUT_TAIL: begin
            if (node_ok_q && !head_q[LINK_W-1]) begin
              rd_en   = 1'b1;
              rd_addr = head_q[IDX_W-1:0];
              cur_d   = head_q[IDX_W-1:0];
              steps_d = CNT_W'(1);
              state_d = S_TAIL_WALK;
            end else begin
              if (!node_ok_q) begin
                res_status = ST_NONE;
              end
              if (out_free) begin
                load_out = 1'b1;
                state_d  = S_IDLE;
              end
            end
          end
          K_NEXT: begin
            if (node_ok_q) begin
              rd_en   = 1'b1;
              rd_addr = node_q;
              state_d = S_NEXT_RD;
            end else begin
              res_status = ST_NONE;
              if (out_free) begin
                load_out = 1'b1;
                state_d  = S_IDLE;
              end
            end
          end
          K_LENGTH: begin
            if (!head_q[LINK_W-1]) begin
              rd_en   = 1'b1;
              rd_addr = head_q[IDX_W-1:0];
              cur_d   = head_q[IDX_W-1:0];
              steps_d = CNT_W'(1);
              total_d = '0;
              state_d = S_LEN_WALK;
            end else if (out_free) begin
              load_out = 1'b1;
              state_d  = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              load_out = 1'b1;
              state_d  = S_IDLE;
            end
          end
        endcase
      end

      S_ALLOC_RD: begin
        res_node = to_field(fh_q);
        if (out_free) begin
          fh_d       = link_rdata;
          data_we    = (kind_e'(kind_q) == K_ALLOC_ATTACH);
          data_waddr = fh_q[IDX_W-1:0];
          data_wdata = {handle_q, size_q};
          load_out   = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_FREE_RD: begin
        res_node = to_field(link_rdata);
        if (out_free) begin
          data_we    = 1'b1;
          link_we    = 1'b1;
          link_wdata = fh_q;
          fh_d       = {1'b0, node_q};
          load_out   = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_TAIL_WALK: begin
        if (link_rdata[LINK_W-1]) begin
          link_we    = 1'b1;
          link_waddr = cur_q;
          link_wdata = {1'b0, node_q};
          state_d    = S_TAIL_END;
        end else if (steps_q == CNT_W'(NODES)) begin
          // No end within the bound: leave the chain alone.
          if (out_free) begin
            load_out = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = link_rdata[IDX_W-1:0];
          cur_d   = link_rdata[IDX_W-1:0];
          steps_d = steps_q + CNT_W'(1);
        end
      end

      S_TAIL_END: begin
        if (out_free) begin
          link_we  = 1'b1;
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_NEXT_RD: begin
        res_link   = to_field(link_rdata);
        res_handle = data_rdata[47:16];
        res_size   = data_rdata[15:0];
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_LEN_WALK: begin
        res_total = sum_sat;
        if (link_rdata[LINK_W-1] || steps_q == CNT_W'(NODES)) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          total_d = sum_sat;
          rd_en   = 1'b1;
          rd_addr = link_rdata[IDX_W-1:0];
          cur_d   = link_rdata[IDX_W-1:0];
          steps_d = steps_q + CNT_W'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      fh_q        <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fh_q    <= fh_d;
      cur_q   <= cur_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q <= steps_d;
    total_q <= total_d;
    if (in_fire) begin
      kind_q    <= kind_i;
      node_q    <= to_idx(node_index_i);
      node_ok_q <= is_node(node_index_i);
      head_q    <= is_node(list_head_i) ? {1'b0, to_idx(list_head_i)} : LINK_NONE;
      handle_q  <= data_handle_i;
      size_q    <= data_size_i;
    end
    if (load_out) begin
      node_res_q   <= res_node;
      link_res_q   <= res_link;
      handle_res_q <= res_handle;
      size_res_q   <= res_size;
      total_res_q  <= res_total;
      status_res_q <= res_status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign node_result_o   = node_res_q;
  assign link_result_o   = link_res_q;
  assign handle_result_o = handle_res_q;
  assign size_result_o   = size_res_q;
  assign total_length_o  = total_res_q;
  assign status_o        = status_res_q;

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL_WALK || state_q == S_LEN_WALK) |->
      (steps_q != '0 && steps_q <= CNT_W'(NODES)))
    else $error("walk step count out of range");

  a_no_raw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && ((link_we && link_waddr == rd_addr) || (data_we && data_waddr == rd_addr))))
    else $error("read and write to the same entry in one cycle");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_EXEC)
    else $error("accepted transaction did not start");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending transaction");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> state_q == S_IDLE)
    else $error("result loaded without closing the transaction");

endmodule

`default_nettype wire
